// File: hw/rtl/owum_pkg.sv
// ----------------------------------------------------------------------------
// owum_pkg
// Shared types and codes for the 1-Wire over UART master.
// ----------------------------------------------------------------------------
package owum_pkg;

  // Default depth of the write byte queue
  localparam int DATA_DEPTH_DEF = 16;

  // UART slot and command bytes
  localparam logic [7:0] BYTE_RESET     = 8'hF0;
  localparam logic [7:0] BYTE_ONE_SLOT  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO_SLOT = 8'h00;
  localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;

  // Prefix sequencer positions, including the first and last of the eight address bytes
  localparam logic [3:0] PFX_MATCH = 4'd0;
  localparam logic [3:0] PFX_ADDR0 = 4'd1;
  localparam logic [3:0] PFX_ADDR7 = 4'd8;
  localparam logic [3:0] PFX_DONE  = 4'd9;
  localparam logic [3:0] PFX_SKIP  = 4'd10;

  // Input opcodes
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_BEGIN_W = 3'd1,
    OP_BEGIN_R = 3'd2,
    OP_ECHO    = 3'd3,
    OP_TX_EMPTY = 3'd4
  } op_t;

  // Rate select codes
  localparam logic [1:0] RSEL_KEEP  = 2'd0;
  localparam logic [1:0] RSEL_RESET = 2'd1;
  localparam logic [1:0] RSEL_DATA  = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DONE    = 2'd1;
  localparam logic [1:0] EV_NO_PRES = 2'd2;

  // Status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] event_code;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [1:0] rate_select;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } res_t;

  // Result descriptor handed from the controller to the output serializer:
  // either one plain item, or a burst of eight slot items for one word
  typedef struct packed {
    logic       slots;
    logic       from_ram;
    logic [7:0] word;
    res_t       item;
  } desc_t;

endpackage

// File: hw/rtl/owum_ram.sv
// ----------------------------------------------------------------------------
// owum_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module owum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/owum_ctrl.sv
// ----------------------------------------------------------------------------
// owum_ctrl
// Transaction controller: decodes each input item, updates the bus state and
// the write queue pointers, drives the queue RAM and issues one result
// descriptor per item.
// ----------------------------------------------------------------------------
module owum_ctrl
  import owum_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  localparam int AW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1,
  localparam int FW  = $clog2(DATA_DEPTH + 1),
  localparam int WLW = ($clog2(DATA_DEPTH + 10) > 8) ? $clog2(DATA_DEPTH + 10) : 8
) (
  input  logic          clk,
  input  logic          rst_n,
  // input items
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    opcode,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    byte_count,
  input  logic [63:0]   match_address,
  // queue RAM
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  // descriptor to the output serializer
  output logic          d_valid,
  output desc_t         d,
  input  logic          d_take
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RESET = 3'd1,
    PH_TX    = 3'd2,
    PH_RX    = 3'd3,
    PH_ERR   = 3'd4
  } phase_t;

  phase_t        phase_r,  phase_nxt;
  logic [2:0]    bc_r,     bc_nxt;
  logic [7:0]    asm_r,    asm_nxt;
  logic [WLW-1:0] wl_r,    wl_nxt;
  logic [3:0]    pfx_r,    pfx_nxt;
  logic [7:0]    dummy_r,  dummy_nxt;
  logic [AW-1:0] head_r,   head_nxt;
  logic [FW-1:0] fill_r,   fill_nxt;
  logic          d_vld_r,  d_vld_nxt;
  desc_t         d_r,      d_nxt;

  logic          acc;
  logic          busy;
  logic          do_send;
  logic [1:0]    send_rate;
  logic [7:0]    asm_new;
  logic [FW:0]   wsum;
  logic [7:0][7:0] addr_bytes;

  assign in_ready   = !d_vld_r || d_take;
  assign acc        = in_valid && in_ready;
  assign busy       = (phase_r == PH_RESET) || (phase_r == PH_TX) || (phase_r == PH_RX);
  assign addr_bytes = match_address;
  assign ram_wdata  = data_byte;
  assign ram_raddr  = head_r;
  assign d_valid    = d_vld_r;
  assign d          = d_r;

  // Queue slot behind the last loaded byte, wrapped
  always_comb begin
    wsum = (FW+1)'(head_r) + (FW+1)'(fill_r);
    if (wsum >= (FW+1)'(DATA_DEPTH)) begin
      wsum = wsum - (FW+1)'(DATA_DEPTH);
    end
  end
  assign ram_waddr = AW'(wsum);

  // Step logic
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    asm_nxt   = asm_r;
    wl_nxt    = wl_r;
    pfx_nxt   = pfx_r;
    dummy_nxt = dummy_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    d_nxt     = d_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    do_send   = 1'b0;
    send_rate = RSEL_KEEP;
    asm_new   = asm_r;

    if (acc) begin
      d_nxt = '0;
      case (op_t'(opcode))
        OP_LOAD: begin
          if (!busy && (fill_r < FW'(DATA_DEPTH))) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end
        OP_BEGIN_W: begin
          if (!busy && (fill_r != '0)) begin
            bc_nxt = 3'd0;
            if (match_address != 64'd0) begin
              pfx_nxt = PFX_MATCH;
              wl_nxt  = WLW'(9) + WLW'(fill_r);
            end else begin
              pfx_nxt = PFX_SKIP;
              wl_nxt  = WLW'(1) + WLW'(fill_r);
            end
            phase_nxt              = PH_RESET;
            d_nxt.item.tx_valid    = 1'b1;
            d_nxt.item.tx_byte     = BYTE_RESET;
            d_nxt.item.rate_select = RSEL_RESET;
          end
        end
        OP_BEGIN_R: begin
          if (!busy && (byte_count != 8'd0)) begin
            head_nxt   = '0;
            fill_nxt   = '0;
            bc_nxt     = 3'd0;
            asm_nxt    = 8'd0;
            wl_nxt     = WLW'(byte_count);
            dummy_nxt  = byte_count - 8'd1;
            phase_nxt  = PH_RX;
            d_nxt.slots = 1'b1;
            d_nxt.word  = BYTE_ONE_SLOT;
          end
        end
        OP_ECHO: begin
          if (phase_r == PH_RESET) begin
            if (data_byte != BYTE_RESET) begin
              phase_nxt = PH_TX;
              do_send   = 1'b1;
              send_rate = RSEL_DATA;
            end else begin
              phase_nxt             = PH_ERR;
              d_nxt.item.event_code = EV_NO_PRES;
            end
          end else if ((phase_r == PH_TX) || (phase_r == PH_RX)) begin
            // Sample bit 0 of a read slot echo
            if ((phase_r == PH_RX) && data_byte[0]) begin
              asm_new = asm_r | (8'd1 << bc_r);
            end
            asm_nxt = asm_new;
            bc_nxt  = bc_r + 3'd1;
            if (bc_r == 3'd7) begin
              if (phase_r == PH_RX) begin
                d_nxt.item.rx_valid = 1'b1;
                d_nxt.item.rx_byte  = asm_new;
                asm_nxt             = 8'd0;
              end
              if (wl_r != '0) begin
                wl_nxt = wl_r - WLW'(1);
              end
              if ((wl_r == '0) || (wl_r == WLW'(1))) begin
                phase_nxt             = PH_IDLE;
                d_nxt.item.event_code = EV_DONE;
              end
            end
          end
        end
        OP_TX_EMPTY: begin
          do_send = 1'b1;
        end
        default: begin
        end
      endcase

      // Next bus word: ROM command, address bytes, then queued data; in a read, a read slot word
      if (do_send) begin
        if (phase_nxt == PH_TX) begin
          if (pfx_r == PFX_SKIP) begin
            d_nxt.slots = 1'b1;
            d_nxt.word  = CMD_SKIP_ROM;
            pfx_nxt     = PFX_DONE;
          end else if (pfx_r == PFX_MATCH) begin
            d_nxt.slots = 1'b1;
            d_nxt.word  = CMD_MATCH_ROM;
            pfx_nxt     = PFX_ADDR0;
          end else if ((pfx_r >= PFX_ADDR0) && (pfx_r <= PFX_ADDR7)) begin
            d_nxt.slots = 1'b1;
            d_nxt.word  = addr_bytes[3'(pfx_r - PFX_ADDR0)];
            pfx_nxt     = pfx_r + 4'd1;
          end else if (fill_r != '0) begin
            d_nxt.slots    = 1'b1;
            d_nxt.from_ram = 1'b1;
            ram_re         = 1'b1;
            head_nxt       = (head_r == AW'(DATA_DEPTH - 1)) ? '0 : head_r + AW'(1);
            fill_nxt       = fill_r - FW'(1);
          end
        end else if (phase_nxt == PH_RX) begin
          if (dummy_r != 8'd0) begin
            dummy_nxt   = dummy_r - 8'd1;
            d_nxt.slots = 1'b1;
            d_nxt.word  = BYTE_ONE_SLOT;
          end
        end
        d_nxt.item.rate_select = send_rate;
      end

      // Status as it stands after the step
      case (phase_nxt)
        PH_IDLE: d_nxt.item.status = ST_IDLE;
        PH_ERR:  d_nxt.item.status = ST_ERR;
        default: d_nxt.item.status = ST_BUSY;
      endcase
    end

    // Descriptor slot
    if (acc) begin
      d_vld_nxt = 1'b1;
    end else if (d_take) begin
      d_vld_nxt = 1'b0;
    end else begin
      d_vld_nxt = d_vld_r;
    end
  end

  // State and descriptor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= 3'd0;
      asm_r   <= 8'd0;
      wl_r    <= '0;
      pfx_r   <= 4'd0;
      dummy_r <= 8'd0;
      head_r  <= '0;
      fill_r  <= '0;
      d_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      asm_r   <= asm_nxt;
      wl_r    <= wl_nxt;
      pfx_r   <= pfx_nxt;
      dummy_r <= dummy_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      d_vld_r <= d_vld_nxt;
    end
    d_r <= d_nxt;
  end

endmodule

// File: hw/rtl/owum_out.sv
// ----------------------------------------------------------------------------
// owum_out
// Output serializer: expands a descriptor into one item or into eight UART
// slot items, least significant bit first, and holds each until taken.
// ----------------------------------------------------------------------------
module owum_out
  import owum_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       d_valid,
  input  desc_t      d,
  output logic       d_take,
  input  logic [7:0] ram_rdata,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_item,
  output logic       out_last
);

  logic       o_vld_r;
  logic       o_slots_r;
  logic [2:0] o_idx_r;
  logic [7:0] o_word_r;
  res_t       o_item_r;
  logic       last_item;
  logic       o_done;

  assign last_item = !o_slots_r || (o_idx_r == 3'd7);
  assign o_done    = o_vld_r && out_ready && last_item;
  assign d_take    = d_valid && (!o_vld_r || o_done);

  // Load a new descriptor, advance through the slots, drop when finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      o_idx_r <= 3'd0;
    end else if (d_take) begin
      o_vld_r <= 1'b1;
      o_idx_r <= 3'd0;
    end else if (o_vld_r && out_ready && !last_item) begin
      o_idx_r <= o_idx_r + 3'd1;
    end else if (o_done) begin
      o_vld_r <= 1'b0;
    end
    if (d_take) begin
      o_slots_r <= d.slots;
      o_word_r  <= d.from_ram ? ram_rdata : d.word;
      o_item_r  <= d.item;
    end
  end

  // Present the current item
  always_comb begin
    out_item = o_item_r;
    out_last = last_item;
    if (o_slots_r) begin
      out_item             = '0;
      out_item.tx_valid    = 1'b1;
      out_item.tx_byte     = o_word_r[o_idx_r] ? BYTE_ONE_SLOT : BYTE_ZERO_SLOT;
      out_item.rate_select = (o_idx_r == 3'd0) ? o_item_r.rate_select : RSEL_KEEP;
      out_item.status      = o_item_r.status;
    end
  end

  assign out_valid = o_vld_r;

endmodule

// File: hw/rtl/one_wire_over_uart_master.sv
// ----------------------------------------------------------------------------
// one_wire_over_uart_master
// 1-Wire bus master carried over a UART: reset/presence, ROM addressing,
// bit slots for writes and reads, with a queue of write bytes in RAM.
// ----------------------------------------------------------------------------
// Path: an input's first result item passes the controller's descriptor register
//   and the serializer's output register; a word's eight slot items then follow
//   one per cycle, and single-result inputs are taken one per cycle, while out_tready
//   is high; after a word, the next descriptor waits until all eight slot items are taken.
// Reset: rst_n clears the bus state, queue pointers and address register; the
//   queue RAM contents are not cleared.
module one_wire_over_uart_master
  import owum_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // opcode[2:0], data_byte[10:3], byte_count[18:11]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // tx_valid[0], tx_byte[8:1], rate_select[10:9],
                                   // rx_valid[11], rx_byte[19:12], event_code[21:20],
                                   // status[23:22]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  logic [63:0]   match_address_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          d_valid;
  desc_t         d;
  logic          d_take;
  res_t          out_item;

  // Address register at byte offset zero
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_address_r <= 64'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[3]) begin
      match_address_r <= cfg_pwdata;
    end
  end
  assign cfg_prdata = cfg_paddr[3] ? 64'd0 : match_address_r;

  owum_ctrl #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .opcode       (in_tdata[2:0]),
    .data_byte    (in_tdata[10:3]),
    .byte_count   (in_tdata[18:11]),
    .match_address(match_address_r),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .d_valid      (d_valid),
    .d            (d),
    .d_take       (d_take)
  );

  owum_ram #(
    .WIDTH(8),
    .DEPTH(DATA_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  owum_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_valid  (d_valid),
    .d        (d),
    .d_take   (d_take),
    .ram_rdata(ram_rdata),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (out_item),
    .out_last (out_tlast)
  );

  assign out_tdata = out_item;

endmodule

// File: hw/rtl/owum_checker.sv
// ----------------------------------------------------------------------------
// owum_checker
// Port-level checks for the 1-Wire over UART master, bound to the top level.
// ----------------------------------------------------------------------------
module owum_checker
  import owum_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result item changed");

  // Within a step the next item follows at once, with rate select KEEP and the same status
  a_step_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tdata[10:9] == RSEL_KEEP) &&
       (out_tdata[23:22] == $past(out_tdata[23:22]))))
    else $error("step items not contiguous or rate repeated");

  // Done leaves the bus idle, a presence failure leaves it in error
  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[21:20] != EV_DONE || out_tdata[23:22] == ST_IDLE) &&
       (out_tdata[21:20] != EV_NO_PRES || out_tdata[23:22] == ST_ERR)))
    else $error("event and status disagree");

endmodule

bind one_wire_over_uart_master owum_checker u_owum_checker (.*);
